// ----- rtl/icmp_ec_pkg.sv -----
// Shared types and constants for the ICMP echo message checker.
`timescale 1ns / 1ps

package icmp_ec_pkg;

   localparam int unsigned COUNT_W = 16;
   localparam int unsigned SUM_W   = 16;

   localparam logic [COUNT_W-1:0] HDR_LEN   = 16'd8;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
   localparam logic [SUM_W-1:0]   SUM_OK    = 16'hFFFF;

   localparam logic [7:0] TYPE_REPLY   = 8'd0;
   localparam logic [7:0] TYPE_REQUEST = 8'd8;
   localparam logic [7:0] CODE_OK      = 8'd0;

   // Header byte positions
   localparam logic [COUNT_W-1:0] POS_TYPE   = 16'd0;
   localparam logic [COUNT_W-1:0] POS_CODE   = 16'd1;
   localparam logic [COUNT_W-1:0] POS_ID_HI  = 16'd4;
   localparam logic [COUNT_W-1:0] POS_ID_LO  = 16'd5;
   localparam logic [COUNT_W-1:0] POS_SEQ_HI = 16'd6;
   localparam logic [COUNT_W-1:0] POS_SEQ_LO = 16'd7;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_TYPE = 2'd1,
      STATUS_SHORT    = 2'd2,
      STATUS_BAD_SUM  = 2'd3
   } status_type;

   typedef struct packed {
      status_type   status;
      logic [7:0]   msg_type;
      logic [7:0]   msg_code;
      logic [15:0]  echo_identifier;
      logic [15:0]  echo_sequence;
      logic [15:0]  data_length;
   } result_type;

endpackage

// ----- rtl/icmp_ec_accum.sv -----
// Byte counter, checksum accumulator, header capture and status decision.
`timescale 1ns / 1ps

module icmp_ec_accum (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               data_byte,
   input  logic                     last_byte,
   output icmp_ec_pkg::result_type  result
);

   logic [icmp_ec_pkg::COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [icmp_ec_pkg::SUM_W-1:0]   running_sum_ff, running_sum_in;
   logic [7:0]                      high_byte_hold_ff, high_byte_hold_in;
   logic                            word_phase_ff, word_phase_in;
   logic [7:0]                      held_type_ff, held_type_in;
   logic [7:0]                      held_code_ff, held_code_in;
   logic [15:0]                     held_identifier_ff, held_identifier_in;
   logic [15:0]                     held_sequence_ff, held_sequence_in;

   logic [15:0] word;
   logic [16:0] raw_sum;
   logic [15:0] folded_sum;
   logic [15:0] count_next;
   logic        type_ok;

   // A lone high byte on the final word is padded with a zero low half.
   assign word       = word_phase_ff ? {high_byte_hold_ff, data_byte} : {data_byte, 8'h00};
   assign raw_sum    = {1'b0, running_sum_ff} + {1'b0, word};
   assign folded_sum = raw_sum[15:0] + {15'd0, raw_sum[16]};
   assign count_next = (byte_count_ff == icmp_ec_pkg::COUNT_MAX) ?
                       byte_count_ff : byte_count_ff + 16'd1;

   always_comb begin
      held_type_in       = held_type_ff;
      held_code_in       = held_code_ff;
      held_identifier_in = held_identifier_ff;
      held_sequence_in   = held_sequence_ff;
      case (byte_count_ff)
         icmp_ec_pkg::POS_TYPE:   held_type_in = data_byte;
         icmp_ec_pkg::POS_CODE:   held_code_in = data_byte;
         icmp_ec_pkg::POS_ID_HI:  held_identifier_in[15:8] = data_byte;
         icmp_ec_pkg::POS_ID_LO:  held_identifier_in[7:0]  = data_byte;
         icmp_ec_pkg::POS_SEQ_HI: held_sequence_in[15:8]   = data_byte;
         icmp_ec_pkg::POS_SEQ_LO: held_sequence_in[7:0]    = data_byte;
         default: ;
      endcase
   end

   always_comb begin
      byte_count_in     = count_next;
      running_sum_in    = word_phase_ff ? folded_sum : running_sum_ff;
      high_byte_hold_in = word_phase_ff ? high_byte_hold_ff : data_byte;
      word_phase_in     = !word_phase_ff;
   end

   assign type_ok = (held_type_in == icmp_ec_pkg::TYPE_REQUEST ||
                     held_type_in == icmp_ec_pkg::TYPE_REPLY) &&
                    held_code_in == icmp_ec_pkg::CODE_OK;

   always_comb begin
      result = '0;
      if (count_next < icmp_ec_pkg::HDR_LEN) begin
         result.status = icmp_ec_pkg::STATUS_SHORT;
      end else if (!type_ok) begin
         result.status = icmp_ec_pkg::STATUS_BAD_TYPE;
      end else if (folded_sum != icmp_ec_pkg::SUM_OK) begin
         result.status = icmp_ec_pkg::STATUS_BAD_SUM;
      end else begin
         result.status          = icmp_ec_pkg::STATUS_OK;
         result.msg_type        = held_type_in;
         result.msg_code        = held_code_in;
         result.echo_identifier = held_identifier_in;
         result.echo_sequence   = held_sequence_in;
         result.data_length     = count_next - icmp_ec_pkg::HDR_LEN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         byte_count_ff      <= '0;
         running_sum_ff     <= '0;
         high_byte_hold_ff  <= '0;
         word_phase_ff      <= 1'b0;
         held_type_ff       <= '0;
         held_code_ff       <= '0;
         held_identifier_ff <= '0;
         held_sequence_ff   <= '0;
      end else if (step) begin
         byte_count_ff      <= byte_count_in;
         running_sum_ff     <= running_sum_in;
         high_byte_hold_ff  <= high_byte_hold_in;
         word_phase_ff      <= word_phase_in;
         held_type_ff       <= held_type_in;
         held_code_ff       <= held_code_in;
         held_identifier_ff <= held_identifier_in;
         held_sequence_ff   <= held_sequence_in;
      end
   end

endmodule

// ----- rtl/icmp_ec_out_reg.sv -----
// Result register with valid/ready handshake.
`timescale 1ns / 1ps

module icmp_ec_out_reg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  icmp_ec_pkg::result_type  load_word,
   input  logic                     out_ready,
   output logic                     out_valid,
   output icmp_ec_pkg::result_type  out_word
);

   logic                    valid_ff;
   icmp_ec_pkg::result_type word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= load_word;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// ----- rtl/icmp_echo_message_checker_top.sv -----
// ICMP echo message checker: input register, accumulator and result register.
// A final byte passes the input register, then loads the result register.
// Throughput: one byte per cycle; the byte stream stalls only when a final
// byte finds the result register still full and not being taken.
// Reset (synchronous, active high) empties both registers and clears the
// running count, checksum and captured header fields.
`timescale 1ns / 1ps

module icmp_echo_message_checker_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_msg_type,
   output logic [7:0]  rsp_msg_code,
   output logic [15:0] rsp_echo_identifier,
   output logic [15:0] rsp_echo_sequence,
   output logic [15:0] rsp_data_length
);

   logic       in_valid_ff;
   logic [7:0] in_data_ff;
   logic       in_last_ff;
   logic       advance;

   icmp_ec_pkg::result_type result;
   icmp_ec_pkg::result_type rsp_word;

   // A final byte may move on only when the result register can take it.
   assign advance   = in_valid_ff && (!in_last_ff || !rsp_valid || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   icmp_ec_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_data_ff),
      .last_byte (in_last_ff),
      .result    (result)
   );

   icmp_ec_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && in_last_ff),
      .load_word (result),
      .out_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_word  (rsp_word)
   );

   assign rsp_status          = rsp_word.status;
   assign rsp_msg_type        = rsp_word.msg_type;
   assign rsp_msg_code        = rsp_word.msg_code;
   assign rsp_echo_identifier = rsp_word.echo_identifier;
   assign rsp_echo_sequence   = rsp_word.echo_sequence;
   assign rsp_data_length     = rsp_word.data_length;

endmodule
